// ----- rtl/core/abl_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Alpha blend package
// Shared widths, register codes and pipeline payload types of the RGBA blender.
// -----------------------------------------------------------------------------
package abl_pkg;

   localparam int CHAN_W     = 8;
   localparam int PROD_W     = 2 * CHAN_W;
   localparam int NUM_W      = 24;
   localparam int DEN_W      = 16;
   localparam int DIV_STEPS  = CHAN_W;
   localparam int APB_ADDR_W = 3;
   localparam int APB_DATA_W = 32;
   localparam int REG_IDX_LSB = 2;
   localparam int NUM_CH     = 3;

   localparam logic [CHAN_W-1:0] FULL_ALPHA = 8'hFF;

   // Register index codes, taken from paddr[2].
   localparam logic REG_MAIN_OPACITY_EN = 1'b0;
   localparam logic REG_STRAIGHT_MODE   = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } rgba_type;

   typedef struct packed {
      rgba_type main_px;
      rgba_type over_px;
   } pair_type;

   typedef struct packed {
      logic main_opacity_enable;
      logic straight_mode;
   } cfg_type;

   typedef struct packed {
      pair_type          px;
      logic              need_div;
      logic [NUM_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic [CHAN_W-1:0] quo;
      logic [CHAN_W-1:0] alpha_mix;
   } div_work_type;

   typedef struct packed {
      logic [NUM_CH-1:0][CHAN_W-1:0] main_col;
      logic [NUM_CH-1:0][CHAN_W-1:0] over_col;
      logic [NUM_CH-1:0][PROD_W-1:0] prod_main;
      logic [NUM_CH-1:0][PROD_W-1:0] prod_over;
      logic                          full;
      logic                          zero;
      logic [CHAN_W-1:0]             alpha;
   } mul_work_type;

endpackage

// ----- rtl/core/abl_req_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Pixel pair request interface
// Valid/ready channel that carries one main pixel and one overlay pixel a beat.
// -----------------------------------------------------------------------------
interface abl_req_if;
   import abl_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] main_red;
   logic [CHAN_W-1:0] main_green;
   logic [CHAN_W-1:0] main_blue;
   logic [CHAN_W-1:0] main_opacity;
   logic [CHAN_W-1:0] over_red;
   logic [CHAN_W-1:0] over_green;
   logic [CHAN_W-1:0] over_blue;
   logic [CHAN_W-1:0] over_alpha;

   modport source (
      output valid, main_red, main_green, main_blue, main_opacity,
             over_red, over_green, over_blue, over_alpha,
      input  ready
   );

   modport sink (
      input  valid, main_red, main_green, main_blue, main_opacity,
             over_red, over_green, over_blue, over_alpha,
      output ready
   );

endinterface

// ----- rtl/core/abl_rsp_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Blended pixel response interface
// Valid/ready channel that carries one blended RGBA pixel a beat.
// -----------------------------------------------------------------------------
interface abl_rsp_if;
   import abl_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_red;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_blue;
   logic [CHAN_W-1:0] out_alpha;

   modport source (
      output valid, out_red, out_green, out_blue, out_alpha,
      input  ready
   );

   modport sink (
      input  valid, out_red, out_green, out_blue, out_alpha,
      output ready
   );

endinterface

// ----- rtl/core/abl_csr.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Alpha blend control registers
// APB-style register file holding the alpha enable and straight mode bits.
// -----------------------------------------------------------------------------
module abl_csr import abl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;
   logic    reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_sel = paddr[REG_IDX_LSB];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_MAIN_OPACITY_EN: cfg_in.main_opacity_enable = pwdata[0];
            REG_STRAIGHT_MODE:   cfg_in.straight_mode       = pwdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MAIN_OPACITY_EN:
            prdata = {{(APB_DATA_W-1){1'b0}}, cfg_ff.main_opacity_enable};
         REG_STRAIGHT_MODE:
            prdata = {{(APB_DATA_W-1){1'b0}}, cfg_ff.straight_mode};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A write to the alpha enable register shows up in the next cycle.
   a_alpha_en_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (reg_sel == REG_MAIN_OPACITY_EN))
         |=> (cfg_ff.main_opacity_enable == $past(pwdata[0])))
      else $error("alpha enable register did not take the written value");

endmodule

// ----- rtl/core/abl_prep.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Alpha blend front stage
// Forms the un-premultiply dividend and divisor and the composited main alpha.
// -----------------------------------------------------------------------------
module abl_prep import abl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  pair_type     in_px,
   output logic         out_valid,
   input  logic         out_ready,
   output div_work_type out_work
);

   logic              valid_ff;
   div_work_type      work_ff, work_in;
   logic [CHAN_W-1:0] oa, ma;
   logic [PROD_W-1:0] prod_am;
   logic [PROD_W-1:0] prod_mix;
   logic [CHAN_W:0]   alpha_sum;
   logic [PROD_W:0]   den_wide;

   assign oa = in_px.over_px.alpha;
   assign ma = in_px.main_px.alpha;

   always_comb begin
      prod_am   = PROD_W'(oa) * PROD_W'(ma);
      prod_mix  = PROD_W'(FULL_ALPHA - ma) * PROD_W'(oa);
      alpha_sum = {1'b0, oa} + {1'b0, ma};
      // 255 * (oa + ma) - oa * ma, always below 2^16.
      den_wide  = ((PROD_W+1)'(alpha_sum) << CHAN_W) - (PROD_W+1)'(alpha_sum)
                  - (PROD_W+1)'(prod_am);

      work_in           = '0;
      work_in.px        = in_px;
      work_in.need_div  = cfg.main_opacity_enable && (oa != '0) && (oa != FULL_ALPHA);
      // 65025 * oa as shifts and adds.
      work_in.rem       = (NUM_W'(oa) << 16) - (NUM_W'(oa) << 9) + NUM_W'(oa);
      work_in.den       = den_wide[DEN_W-1:0];
      work_in.quo       = '0;
      work_in.alpha_mix = ma + prod_mix[PROD_W-1:CHAN_W];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

   // Compositing over never lowers the main alpha.
   a_alpha_mix_floor: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (work_ff.alpha_mix >= work_ff.px.main_px.alpha))
      else $error("composited alpha fell below main alpha");

endmodule

// ----- rtl/core/abl_div_stage.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Alpha blend divider step
// One restoring division step that settles a single quotient bit.
// -----------------------------------------------------------------------------
module abl_div_stage import abl_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  div_work_type in_work,
   output logic         out_valid,
   input  logic         out_ready,
   output div_work_type out_work
);

   logic             valid_ff;
   div_work_type     work_ff, work_in;
   logic [NUM_W-1:0] den_sh;
   logic             take;

   always_comb begin
      den_sh  = NUM_W'(in_work.den) << BIT;
      take    = in_work.rem >= den_sh;
      work_in = in_work;
      if (take) begin
         work_in.rem      = in_work.rem - den_sh;
         work_in.quo[BIT] = 1'b1;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

   // After this step the partial remainder is below the shifted divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && work_ff.need_div) |-> (work_ff.rem < (NUM_W'(work_ff.den) << BIT)))
      else $error("divider remainder out of range");

endmodule

// ----- rtl/core/abl_mix.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Alpha blend back end
// Weight products in one stage, colour blend, saturation and selection in the next.
// -----------------------------------------------------------------------------
module abl_mix import abl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  div_work_type in_work,
   output logic         out_valid,
   input  logic         out_ready,
   output rgba_type     out_px
);

   logic              mul_valid_ff;
   mul_work_type      mul_ff, mul_in;
   logic              pix_valid_ff;
   rgba_type          pix_ff, pix_in;
   logic              mul_ready, pix_ready;
   logic [CHAN_W-1:0] weight;
   logic [CHAN_W-1:0] weight_inv;

   logic [NUM_CH-1:0][CHAN_W-1:0] res_col;

   // Weight products.
   always_comb begin
      weight     = in_work.need_div ? in_work.quo : in_work.px.over_px.alpha;
      weight_inv = FULL_ALPHA - weight;

      mul_in          = '0;
      mul_in.main_col = {in_work.px.main_px.red, in_work.px.main_px.green,
                         in_work.px.main_px.blue};
      mul_in.over_col = {in_work.px.over_px.red, in_work.px.over_px.green,
                         in_work.px.over_px.blue};
      for (int ch = 0; ch < NUM_CH; ch++) begin
         mul_in.prod_main[ch] = PROD_W'(mul_in.main_col[ch]) * PROD_W'(weight_inv);
         mul_in.prod_over[ch] = PROD_W'(mul_in.over_col[ch]) * PROD_W'(weight);
      end
      mul_in.full = (weight == FULL_ALPHA);
      mul_in.zero = (weight == '0);

      if (!cfg.main_opacity_enable || mul_in.zero) begin
         mul_in.alpha = in_work.px.main_px.alpha;
      end else if (mul_in.full) begin
         mul_in.alpha = in_work.px.over_px.alpha;
      end else begin
         mul_in.alpha = in_work.alpha_mix;
      end
   end

   // Blend, saturation and selection.
   always_comb begin
      logic [PROD_W:0]   sum_st;
      logic [CHAN_W:0]   sum_pm;
      logic [CHAN_W-1:0] blend;
      sum_st  = '0;
      sum_pm  = '0;
      blend   = '0;
      res_col = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum_st = (PROD_W+1)'(mul_ff.prod_main[ch]) + (PROD_W+1)'(mul_ff.prod_over[ch]);
         sum_pm = (CHAN_W+1)'(mul_ff.prod_main[ch][PROD_W-1:CHAN_W])
                  + (CHAN_W+1)'(mul_ff.over_col[ch]);
         if (cfg.straight_mode) begin
            blend = sum_st[PROD_W-1:CHAN_W];
         end else begin
            blend = sum_pm[CHAN_W] ? FULL_ALPHA : sum_pm[CHAN_W-1:0];
         end
         priority if (mul_ff.full) begin
            res_col[ch] = mul_ff.over_col[ch];
         end else if (mul_ff.zero) begin
            res_col[ch] = mul_ff.main_col[ch];
         end else begin
            res_col[ch] = blend;
         end
      end
      pix_in.red   = res_col[2];
      pix_in.green = res_col[1];
      pix_in.blue  = res_col[0];
      pix_in.alpha = mul_ff.alpha;
   end

   assign pix_ready = !pix_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || pix_ready;
   assign in_ready  = mul_ready;
   assign out_valid = pix_valid_ff;
   assign out_px    = pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         pix_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) begin
            mul_valid_ff <= in_valid;
         end
         if (pix_ready) begin
            pix_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         mul_ff <= mul_in;
      end
      if (pix_ready && mul_valid_ff) begin
         pix_ff <= pix_in;
      end
   end

endmodule

// ----- rtl/core/rgba_pixel_alpha_blend_core.sv -----
`timescale 1ns / 1ps
// An accepted request beat passes through the front stage, eight divider steps, the
// product stage and the blend stage before it leaves as its response beat.
// Throughput: one pixel pair per clock; every stage holds its own valid bit, so bubbles
// are squeezed out and a stalled response holds the input only once every stage is full.
// Reset (synchronous, active high) clears all valid bits and both control registers.
// -----------------------------------------------------------------------------
// RGBA alpha blend core
// Composites one overlay RGBA8 pixel onto one main RGBA8 pixel per beat.
// -----------------------------------------------------------------------------
module rgba_pixel_alpha_blend_core import abl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   abl_req_if.sink               req_bus,
   abl_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready
);

   // The pipeline runs front stage, then eight divider steps, then the weight
   // product stage and the blend/output stage. The divider steps carry the
   // whole pixel along even when no division is needed, so every beat has the
   // same latency and order is kept without any reordering logic.

   cfg_type      cfg;
   pair_type     req_px;
   rgba_type     rsp_px;

   logic                       div_valid [0:DIV_STEPS];
   logic                       div_ready [0:DIV_STEPS];
   div_work_type               div_work  [0:DIV_STEPS];

   // Control registers. Writes are expected only while the pipeline is empty,
   // so the stages read the live register values.
   abl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_px.main_px.red   = req_bus.main_red;
   assign req_px.main_px.green = req_bus.main_green;
   assign req_px.main_px.blue  = req_bus.main_blue;
   assign req_px.main_px.alpha = req_bus.main_opacity;
   assign req_px.over_px.red   = req_bus.over_red;
   assign req_px.over_px.green = req_bus.over_green;
   assign req_px.over_px.blue  = req_bus.over_blue;
   assign req_px.over_px.alpha = req_bus.over_alpha;

   // Front stage: the dividend 65025 * oa, the divisor
   // 255 * (oa + ma) - oa * ma and the composited main alpha.
   abl_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_px     (req_px),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_work  (div_work[0])
   );

   // Restoring divider, most significant quotient bit first. The quotient never
   // exceeds 255, so eight steps give the exact un-premultiplied weight.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      abl_div_stage #(
         .BIT (DIV_STEPS - 1 - k)
      ) u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_work   (div_work[k]),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_work  (div_work[k+1])
      );
   end

   // Back end: weight products, then the straight or premultiplied blend with
   // the transparent and opaque special cases, into the output register.
   abl_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (div_valid[DIV_STEPS]),
      .in_ready  (div_ready[DIV_STEPS]),
      .in_work   (div_work[DIV_STEPS]),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_px    (rsp_px)
   );

   assign rsp_bus.out_red   = rsp_px.red;
   assign rsp_bus.out_green = rsp_px.green;
   assign rsp_bus.out_blue  = rsp_px.blue;
   assign rsp_bus.out_alpha = rsp_px.alpha;

endmodule
